// ===== hw/rtl/anep_pkg.sv =====
// shared types, codes and constants for the ascii number entry parser
`timescale 1ns / 1ps

package anep_pkg;

    // command codes passed from the classifier to the executor
    localparam logic [1:0] OP_DIGIT = 2'd0;
    localparam logic [1:0] OP_BS    = 2'd1;
    localparam logic [1:0] OP_CR    = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_BS = 8'd8;

    localparam logic       KIND_ECHO   = 1'b0;
    localparam logic       KIND_NUMBER = 1'b1;

    // floor(x / 10) == (x * RECIP_DIV10) >> DIV10_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam int ANEP_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_char;
        logic [3:0] digit;
        logic       hex;
    } cmd_t;

endpackage

// ===== hw/rtl/ascii_number_entry_parser_unit.sv =====
// top level of the ascii number entry parser
`timescale 1ns / 1ps

// ascii number entry parser: takes one received character per item on the
// in channel and builds an unsigned 32-bit number, decimal or hex as set by
// the one-bit mode register on the cfg port (write only while idle). a digit
// yields an echo item, a backspace with digits pending yields an echo and
// drops the last digit, a carriage return yields the finished number and
// clears the entry, anything else yields nothing. throughput is one item per
// clock when nothing stalls; an accepted character is queued and then
// registered at the output before it shows on the out channel. the front
// classifies each character in the cycle it is accepted, a short command
// queue (QUEUE_DEPTH entries) sits between the front and the executor, and
// the executor updates the value (constant multiply for the digit,
// reciprocal multiply for the divide by ten) into a registered output stage.
module ascii_number_entry_parser_unit
    import anep_pkg::*;
#(
    parameter int QUEUE_DEPTH = ANEP_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // mode register write port
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // character items in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_char,
    // result items out
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  echo_char,
    output logic [31:0] entered_value
);

    // classifier to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to executor
    logic pop;
    logic q_not_empty;
    cmd_t head_cmd;

    // front end: mode register and character classification
    anep_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_char   (rx_char),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decouples the two sides so either can stall on its own
    anep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // executor: value and digit count, output register
    anep_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .echo_char     (echo_char),
        .entered_value (entered_value)
    );

endmodule

// ===== hw/rtl/anep_front.sv =====
// front end: holds the mode register and classifies received characters
`timescale 1ns / 1ps

module anep_front
    import anep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_char,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic hex_mode_reg;
    logic hex_mode_next;
    logic is_digit;
    logic keep;
    logic [3:0] digit_val;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        hex_mode_next = hex_mode_reg;
        if (cfg_valid)
        begin
            hex_mode_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_mode_reg <= 1'b0;
        end
        else
        begin
            hex_mode_reg <= hex_mode_next;
        end
    end

    // digit decode for the mode in force at arrival
    always_comb
    begin
        is_digit  = 1'b0;
        digit_val = 4'd0;
        if (rx_char >= "0" && rx_char <= "9")
        begin
            is_digit  = 1'b1;
            digit_val = 4'(rx_char - "0");
        end
        else if (hex_mode_reg && rx_char >= "A" && rx_char <= "F")
        begin
            is_digit  = 1'b1;
            digit_val = 4'(rx_char - "A" + 8'd10);
        end
        else if (hex_mode_reg && rx_char >= "a" && rx_char <= "f")
        begin
            is_digit  = 1'b1;
            digit_val = 4'(rx_char - "a" + 8'd10);
        end
    end

    always_comb
    begin
        keep             = 1'b1;
        push_cmd.rx_char = rx_char;
        push_cmd.digit   = digit_val;
        push_cmd.hex     = hex_mode_reg;
        push_cmd.op      = OP_DIGIT;
        if (rx_char == CHAR_CR)
        begin
            push_cmd.op = OP_CR;
        end
        else if (is_digit)
        begin
            push_cmd.op = OP_DIGIT;
        end
        else if (rx_char == CHAR_BS)
        begin
            push_cmd.op = OP_BS;
        end
        else
        begin
            keep = 1'b0;
        end
    end

    // ignored characters are accepted and dropped here
    assign in_stall = q_full;
    assign push     = in_valid && !q_full && keep;

endmodule

// ===== hw/rtl/anep_queue.sv =====
// small command queue between the classifier and the executor
`timescale 1ns / 1ps

module anep_queue
    import anep_pkg::*;
#(
    parameter int DEPTH = ANEP_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/anep_back.sv =====
// back end: running value, digit count and the registered result
`timescale 1ns / 1ps

module anep_back
    import anep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [7:0]  echo_char,
    output logic [31:0] entered_value
);

    logic [31:0] value_reg, value_next;
    logic [15:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  echo_reg, echo_next;
    logic [31:0] entered_reg, entered_next;

    logic        produce;
    logic [31:0] value_shifted;
    logic [63:0] recip_prod;
    logic [31:0] value_div;

    assign pop = q_not_empty && (!out_valid_reg || !out_stall);

    // value * base, wrapping
    assign value_shifted = head_cmd.hex ? {value_reg[27:0], 4'd0}
                                        : ({value_reg[28:0], 3'd0} + {value_reg[30:0], 1'b0});

    assign recip_prod = {32'd0, value_reg} * {32'd0, RECIP_DIV10};
    assign value_div  = head_cmd.hex ? {4'd0, value_reg[31:4]}
                                     : {3'd0, recip_prod[63:DIV10_SHIFT]};

    always_comb
    begin
        value_next   = value_reg;
        count_next   = count_reg;
        produce      = 1'b0;
        kind_next    = kind_reg;
        echo_next    = echo_reg;
        entered_next = entered_reg;
        if (pop)
        begin
            unique case (head_cmd.op)
                OP_CR:
                begin
                    produce      = 1'b1;
                    kind_next    = KIND_NUMBER;
                    echo_next    = 8'd0;
                    entered_next = value_reg;
                    value_next   = 32'd0;
                    count_next   = 16'd0;
                end
                OP_DIGIT:
                begin
                    produce      = 1'b1;
                    kind_next    = KIND_ECHO;
                    echo_next    = head_cmd.rx_char;
                    entered_next = 32'd0;
                    value_next   = value_shifted + {28'd0, head_cmd.digit};
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                end
                OP_BS:
                begin
                    if (count_reg != 16'd0)
                    begin
                        produce      = 1'b1;
                        kind_next    = KIND_ECHO;
                        echo_next    = head_cmd.rx_char;
                        entered_next = 32'd0;
                        value_next   = value_div;
                        count_next   = count_reg - 16'd1;
                    end
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= 32'd0;
            count_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            value_reg     <= value_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            kind_reg    <= kind_next;
            echo_reg    <= echo_next;
            entered_reg <= entered_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign echo_char     = echo_reg;
    assign entered_value = entered_reg;

endmodule

// ===== dv/ascii_number_entry_parser_unit_test.sv =====
// self-checking testbench for the ascii number entry parser unit
`timescale 1ns / 1ps

module ascii_number_entry_parser_unit_test;
    import anep_pkg::*;

    // a dropped backspace still passes through the command queue, so
    // this many quiet cycles guarantee that it has drained
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 870;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [7:0] NOT_A_DIGIT = 8'd16;

    // one result item as seen on the out channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  echo;
        logic [31:0] value;
    } result_t;

    // how the expected result of a stimulus row is obtained
    typedef enum logic [2:0] {
        ROW_PREDICT,  // from the predictor
        ROW_NONE,     // character is dropped, no result
        ROW_ECHO,     // echo of the character itself
        ROW_NUMBER,   // finished number given in the row
        ROW_MODE      // not a character: write bit 0 of ch to the mode register
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [7:0]  ch;
        logic [31:0] value;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 30;

    // short directed walk: field extremes, digit range boundaries in both
    // modes, backspace with and without pending digits, value wrap-around
    // and a mode change in the middle of an entry
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        {ROW_NUMBER,  CHAR_CR, 32'd0},        // entry right after reset
        {ROW_NONE,    CHAR_BS, 32'd0},        // backspace with nothing pending
        {ROW_NONE,    8'h00,   32'd0},
        {ROW_NONE,    8'hFF,   32'd0},
        {ROW_NONE,    "/",     32'd0},        // just below '0'
        {ROW_NONE,    ":",     32'd0},        // just above '9'
        {ROW_NONE,    "a",     32'd0},        // hex letter in decimal mode
        {ROW_ECHO,    "0",     32'd0},
        {ROW_ECHO,    "9",     32'd0},
        {ROW_ECHO,    CHAR_BS, 32'd0},
        {ROW_ECHO,    "7",     32'd0},
        {ROW_PREDICT, CHAR_CR, 32'd0},
        {ROW_MODE,    8'd1,    32'd0},
        {ROW_NONE,    "G",     32'd0},        // just above 'F'
        {ROW_NONE,    "@",     32'd0},        // just below 'A'
        {ROW_ECHO,    "A",     32'd0},
        {ROW_ECHO,    "F",     32'd0},
        {ROW_ECHO,    "F",     32'd0},
        {ROW_ECHO,    "F",     32'd0},
        {ROW_ECHO,    "F",     32'd0},
        {ROW_ECHO,    "F",     32'd0},
        {ROW_ECHO,    "F",     32'd0},
        {ROW_ECHO,    "f",     32'd0},
        {ROW_ECHO,    "a",     32'd0},        // ninth digit, leading A wraps out
        {ROW_ECHO,    CHAR_BS, 32'd0},
        {ROW_NUMBER,  CHAR_CR, 32'h0FFF_FFFF},
        {ROW_ECHO,    "b",     32'd0},
        {ROW_MODE,    8'd0,    32'd0},        // switch to decimal mid entry
        {ROW_ECHO,    "5",     32'd0},
        {ROW_PREDICT, CHAR_CR, 32'd0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_data      = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_char       = 8'd0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        result_kind;
    logic [7:0]  echo_char;
    logic [31:0] entered_value;

    // predictor state: mode register, pending value and digit count
    logic        hex_mode_model = 1'b0;
    logic [31:0] entry_value    = '0;
    logic [15:0] entry_digits   = '0;

    result_t     pending_results [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;
    bit          in_idle_on     = 1'b1;
    bit          out_idle_on    = 1'b1;

    always #5 clk = ~clk;

    ascii_number_entry_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_char       (rx_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .echo_char     (echo_char),
        .entered_value (entered_value)
    );

    // applies one character to the predictor state, returns 1 with the
    // result when the character produces one
    function automatic bit predict_char(input logic [7:0] ch, output result_t res);
        logic [7:0]  digit;
        logic [31:0] base;
        base  = hex_mode_model ? 32'd16 : 32'd10;
        res   = '0;
        digit = NOT_A_DIGIT;
        if (ch == CHAR_CR)
        begin
            res.kind     = KIND_NUMBER;
            res.value    = entry_value;
            entry_value  = '0;
            entry_digits = '0;
            return 1'b1;
        end
        if (ch >= "0" && ch <= "9")
            digit = ch - "0";
        else if (hex_mode_model && ch >= "A" && ch <= "F")
            digit = ch - "A" + 8'd10;
        else if (hex_mode_model && ch >= "a" && ch <= "f")
            digit = ch - "a" + 8'd10;
        if (digit < base)
        begin
            // wraps modulo 2^32, count saturates
            entry_value = entry_value * base + digit;
            if (entry_digits != COUNT_MAX)
                entry_digits++;
            res.kind = KIND_ECHO;
            res.echo = ch;
            return 1'b1;
        end
        if (ch == CHAR_BS && entry_digits != 0)
        begin
            entry_value = entry_value / base;
            entry_digits--;
            res.kind = KIND_ECHO;
            res.echo = ch;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // a valid digit for the given mode, hex letters in either case
    function automatic logic [7:0] random_digit(input logic hex);
        logic [7:0] d;
        d = 8'($urandom_range(0, hex ? 15 : 9));
        if (d < 8'd10)
            return "0" + d;
        return ($urandom_range(0, 1) != 0) ? ("A" + d - 8'd10) : ("a" + d - 8'd10);
    endfunction

    // records the expectation for one character, then hands the item over
    // after a random gap; returns at the edge where it is accepted
    task automatic send_char(input logic [7:0] ch, input row_kind_e how,
                             input logic [31:0] typed_value);
        result_t predicted;
        result_t typed;
        bit      has_result;
        int      gap;
        has_result = predict_char(ch, predicted);
        typed      = '0;
        case (how)
            ROW_ECHO:
            begin
                typed.kind = KIND_ECHO;
                typed.echo = ch;
                pending_results.push_back(typed);
            end
            ROW_NUMBER:
            begin
                typed.kind  = KIND_NUMBER;
                typed.value = typed_value;
                pending_results.push_back(typed);
            end
            ROW_PREDICT:
                if (has_result)
                    pending_results.push_back(predicted);
            default: ;
        endcase
        items_sent++;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_char  <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // mode writes only happen with the unit drained
    task automatic write_mode(input logic mode);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid      <= 1'b0;
        hex_mode_model  = mode;
    endtask

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch, %s: expected kind %0d echo %02h value %08h,",
                      " got kind %0d echo %02h value %08h"},
                     what, want.kind, want.echo, want.value, got.kind, got.echo, got.value);
    endtask

    // result checker and out side stall generator; every accepted result is
    // compared with the oldest expectation, then a fresh hold-off is drawn
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {result_kind, echo_char, entered_value};
            if (pending_results.size() == 0)
                note_mismatch("no result expected", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.echo !== want.echo
                    || got.value !== want.value)
                    note_mismatch("wrong field", want, got);
            end
            stall_left = out_idle_on ? $urandom_range(0, 9) : 0;
        end
        else if (stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int digits;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_MODE)
                write_mode(directed_rows[i].ch[0]);
            else
                send_char(directed_rows[i].ch, directed_rows[i].kind, directed_rows[i].value);
        end

        // random phases: mostly well-formed entries with random digits,
        // backspaces and stray characters, some cut short so the next mode
        // write lands in the middle of an entry
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            write_mode(1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // burst of arbitrary bytes
                    repeat ($urandom_range(1, 5))
                        send_char(8'($urandom_range(0, 255)), ROW_PREDICT, '0);
                end
                else
                begin
                    // long entries now and then to force wrap-around
                    digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
                                                         : $urandom_range(0, 6);
                    repeat (digits)
                    begin
                        send_char(random_digit(hex_mode_model), ROW_PREDICT, '0);
                        if ($urandom_range(0, 5) == 0)
                            send_char(CHAR_BS, ROW_PREDICT, '0);
                        if ($urandom_range(0, 11) == 0)
                            send_char(8'($urandom_range(0, 255)), ROW_PREDICT, '0);
                    end
                    if ($urandom_range(0, 5) == 0)
                        send_char(CHAR_BS, ROW_PREDICT, '0);
                    if ($urandom_range(0, 9) != 0)
                        send_char(CHAR_CR, ROW_PREDICT, '0);
                end
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
